/* rtl/core/esc_dec_pkg.sv */
// Shared types and constants for the escape sequence decoder.
package esc_dec_pkg;

    localparam logic [2:0] PH_PLAIN  = 3'd0;
    localparam logic [2:0] PH_BSLASH = 3'd1;
    localparam logic [2:0] PH_HEX0   = 3'd2;
    localparam logic [2:0] PH_HEX1   = 3'd3;
    localparam logic [2:0] PH_OCT1   = 3'd4;
    localparam logic [2:0] PH_OCT2   = 3'd5;

    localparam logic [1:0] KIND_BYTE = 2'd0;
    localparam logic [1:0] KIND_END  = 2'd1;
    localparam logic [1:0] KIND_ERR  = 2'd2;

    localparam logic [7:0] TERM_RESET = 8'h22;

    localparam logic [7:0] CH_NUL    = 8'h00;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_0      = 8'h30;
    localparam logic [7:0] CH_7      = 8'h37;
    localparam logic [7:0] CH_9      = 8'h39;
    localparam logic [7:0] CH_LA     = 8'h61;
    localparam logic [7:0] CH_LF     = 8'h66;
    localparam logic [7:0] CH_UA     = 8'h41;
    localparam logic [7:0] CH_UF     = 8'h46;
    localparam logic [7:0] CH_LX     = 8'h78;
    localparam logic [7:0] CH_UX     = 8'h58;
    localparam logic [7:0] CH_LB     = 8'h62;
    localparam logic [7:0] CH_LN     = 8'h6E;
    localparam logic [7:0] CH_LR     = 8'h72;
    localparam logic [7:0] CH_LT     = 8'h74;
    localparam logic [7:0] CH_LV     = 8'h76;

    localparam logic [7:0] VAL_BEL = 8'h07;
    localparam logic [7:0] VAL_BS  = 8'h08;
    localparam logic [7:0] VAL_FF  = 8'h0C;
    localparam logic [7:0] VAL_NL  = 8'h0A;
    localparam logic [7:0] VAL_CR  = 8'h0D;
    localparam logic [7:0] VAL_TAB = 8'h09;
    localparam logic [7:0] VAL_VT  = 8'h0B;

    localparam int QDEPTH   = 4;
    localparam int Q_PTR_W  = $clog2(QDEPTH);
    localparam int Q_CNT_W  = $clog2(QDEPTH + 1);

    typedef struct packed {
        logic [7:0] data;
        logic [1:0] kind;
        logic       last;
    } result_t;

endpackage

/* rtl/core/escape_sequence_decoder.sv */
// Top level of the escape sequence decoder: input stage, decode logic and result queue.
//
//   channel  direction  signals                                   moves
//   in       sink       in_valid, in_ready, in_byte               one source byte per item
//   out      source     out_valid, out_ready, out_byte,           one result per item
//                       out_kind, last
//   cfg      sink       cfg_valid, cfg_ready, terminator_char     terminator register write
//
// An accepted byte is held in the input register, is decoded there and its zero,
// one or two results are written into a four-entry result queue in the same cycle.
// One byte per cycle is sustained while each byte gives at most one result and out_ready
// is high; a byte with two results leaves as two items. The input register advances only
// when the queue has room for two results. Reset clears the queue, the input register, the
// escape state and sets the terminator to a double quote. The config port never stalls.
module escape_sequence_decoder
    import esc_dec_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] in_byte,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [7:0] out_byte,
    output logic [1:0] out_kind,
    output logic       last,
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic [7:0] terminator_char
);

    logic [7:0]         term_reg;
    logic               s1_valid_reg;
    logic [7:0]         s1_byte_reg;
    logic [2:0]         phase_reg;
    logic [2:0]         phase_next;
    logic [7:0]         value_reg;
    logic [7:0]         value_next;
    result_t            queue_reg [QDEPTH];
    logic [Q_PTR_W-1:0] wr_ptr_reg;
    logic [Q_PTR_W-1:0] rd_ptr_reg;
    logic [Q_CNT_W-1:0] count_reg;
    logic [Q_CNT_W-1:0] count_next;

    logic               s1_advance;
    logic               pop;
    logic [1:0]         push_n;
    logic [7:0]         c;
    logic               is_hex;
    logic               is_oct;
    logic [3:0]         hex_val;
    logic               emit_a;
    logic [7:0]         a_data;
    logic [1:0]         a_kind;
    logic               run_plain;
    logic               p_emit;
    logic [7:0]         p_data;
    logic [1:0]         p_kind;
    logic [2:0]         p_phase;
    result_t            res0;
    result_t            res1;
    result_t            head;

    assign cfg_ready  = 1'b1;
    assign s1_advance = s1_valid_reg && (count_reg <= Q_CNT_W'(QDEPTH - 2));
    assign in_ready   = !s1_valid_reg || s1_advance;
    assign pop        = out_valid && out_ready;
    assign c          = s1_byte_reg;

    always_comb
    begin
        is_oct  = (c inside {[CH_0:CH_7]});
        is_hex  = 1'b1;
        hex_val = c[3:0];
        if (c inside {[CH_0:CH_9]})
        begin
            hex_val = c[3:0];
        end
        else if (c inside {[CH_LA:CH_LF], [CH_UA:CH_UF]})
        begin
            hex_val = c[3:0] + 4'd9;
        end
        else
        begin
            is_hex = 1'b0;
        end
    end

    always_comb
    begin
        p_data = c;
        p_kind = KIND_BYTE;
        p_emit = 1'b1;
        p_phase = PH_PLAIN;
        if (c == CH_BSLASH)
        begin
            p_emit  = 1'b0;
            p_phase = PH_BSLASH;
        end
        else if (c == term_reg)
        begin
            p_data = CH_NUL;
            p_kind = KIND_END;
        end
    end

    always_comb
    begin
        emit_a     = 1'b0;
        a_data     = value_reg;
        a_kind     = KIND_BYTE;
        run_plain  = 1'b0;
        phase_next = phase_reg;
        value_next = value_reg;
        if (c == CH_NUL)
        begin
            emit_a     = 1'b1;
            a_data     = CH_NUL;
            a_kind     = KIND_ERR;
            phase_next = PH_PLAIN;
            value_next = 8'd0;
        end
        else
        begin
            case (phase_reg)
                PH_BSLASH:
                begin
                    phase_next = PH_PLAIN;
                    emit_a     = 1'b1;
                    case (c)
                        CH_LX, CH_UX:
                        begin
                            emit_a     = 1'b0;
                            phase_next = PH_HEX0;
                        end
                        CH_LA:   a_data = VAL_BEL;
                        CH_LB:   a_data = VAL_BS;
                        CH_LF:   a_data = VAL_FF;
                        CH_LN:   a_data = VAL_NL;
                        CH_LR:   a_data = VAL_CR;
                        CH_LT:   a_data = VAL_TAB;
                        CH_LV:   a_data = VAL_VT;
                        default:
                        begin
                            if (is_oct)
                            begin
                                emit_a     = 1'b0;
                                value_next = {5'd0, c[2:0]};
                                phase_next = PH_OCT1;
                            end
                            else
                            begin
                                a_data = c;
                            end
                        end
                    endcase
                end
                PH_HEX0:
                begin
                    if (is_hex)
                    begin
                        value_next = {4'd0, hex_val};
                        phase_next = PH_HEX1;
                    end
                    else
                    begin
                        emit_a     = 1'b1;
                        a_data     = CH_NUL;
                        run_plain  = 1'b1;
                        phase_next = p_phase;
                    end
                end
                PH_HEX1:
                begin
                    emit_a = 1'b1;
                    if (is_hex)
                    begin
                        value_next = {value_reg[3:0], hex_val};
                        a_data     = {value_reg[3:0], hex_val};
                        phase_next = PH_PLAIN;
                    end
                    else
                    begin
                        run_plain  = 1'b1;
                        phase_next = p_phase;
                    end
                end
                PH_OCT1:
                begin
                    if (is_oct)
                    begin
                        value_next = {value_reg[4:0], c[2:0]};
                        phase_next = PH_OCT2;
                    end
                    else
                    begin
                        emit_a     = 1'b1;
                        run_plain  = 1'b1;
                        phase_next = p_phase;
                    end
                end
                PH_OCT2:
                begin
                    emit_a = 1'b1;
                    if (is_oct)
                    begin
                        value_next = {value_reg[4:0], c[2:0]};
                        a_data     = {value_reg[4:0], c[2:0]};
                        phase_next = PH_PLAIN;
                    end
                    else
                    begin
                        run_plain  = 1'b1;
                        phase_next = p_phase;
                    end
                end
                default:
                begin
                    run_plain  = 1'b1;
                    phase_next = p_phase;
                end
            endcase
        end
    end

    always_comb
    begin
        res1 = '{data: p_data, kind: p_kind, last: 1'b1};
        if (emit_a)
        begin
            res0   = '{data: a_data, kind: a_kind, last: !(run_plain && p_emit)};
            push_n = (run_plain && p_emit) ? 2'd2 : 2'd1;
        end
        else
        begin
            res0   = '{data: p_data, kind: p_kind, last: 1'b1};
            push_n = (run_plain && p_emit) ? 2'd1 : 2'd0;
        end
        if (!s1_advance)
        begin
            push_n = 2'd0;
        end
    end

    assign count_next = count_reg + Q_CNT_W'(push_n) - Q_CNT_W'(pop);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            term_reg     <= TERM_RESET;
            s1_valid_reg <= 1'b0;
            phase_reg    <= PH_PLAIN;
            value_reg    <= 8'd0;
            wr_ptr_reg   <= '0;
            rd_ptr_reg   <= '0;
            count_reg    <= '0;
        end
        else
        begin
            if (cfg_valid)
            begin
                term_reg <= terminator_char;
            end
            if (in_ready)
            begin
                s1_valid_reg <= in_valid;
            end
            if (s1_advance)
            begin
                phase_reg <= phase_next;
                value_reg <= value_next;
            end
            wr_ptr_reg <= wr_ptr_reg + Q_PTR_W'(push_n);
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            s1_byte_reg <= in_byte;
        end
        if (push_n != 2'd0)
        begin
            queue_reg[wr_ptr_reg] <= res0;
        end
        if (push_n == 2'd2)
        begin
            queue_reg[wr_ptr_reg + 1'b1] <= res1;
        end
    end

    assign head      = queue_reg[rd_ptr_reg];
    assign out_valid = (count_reg != '0);
    assign out_byte  = head.data;
    assign out_kind  = head.kind;
    assign last      = head.last;

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= Q_CNT_W'(QDEPTH))
        else $error("result queue count exceeds its depth");

    a_ptr_track: assert property (@(posedge clk) disable iff (!rst_n)
        (wr_ptr_reg - rd_ptr_reg) == count_reg[Q_PTR_W-1:0])
        else $error("result queue pointers disagree with the count");

    a_nul_resets: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_advance && s1_byte_reg == CH_NUL) |=> (phase_reg == PH_PLAIN && value_reg == 8'd0))
        else $error("zero byte did not return the escape state to reset");

    a_nul_single: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_advance && s1_byte_reg == CH_NUL) |-> (push_n == 2'd1 && res0.kind == KIND_ERR))
        else $error("zero byte must give exactly one error result");

    a_marker_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_kind != KIND_BYTE) |-> (out_byte == CH_NUL))
        else $error("end or error result carries a nonzero byte");
`endif

endmodule
